/* design/assert_macros.svh */
// assertion macros for the range k-th smallest unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DRKS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DRKS_ASSERT_NORST(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRKS_ASSERT(name, clk, rst, prop, msg)
`define DRKS_ASSERT_NORST(name, clk, prop, msg)
`endif
`endif

/* design/drks_pkg.sv */
package drks_pkg;

   localparam int POS_W     = 11;
   localparam int RANK_W    = 10;
   localparam int K_W       = 11;
   localparam int CFG_W     = 11;
   localparam int CNT_W     = 11;
   localparam int ACC_W     = CNT_W + 1;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam int DEF_MAX_POSITIONS = 1024;
   localparam int DEF_MAX_RANKS     = 1024;
   localparam int CFG_RESET_VALUE   = 1024;

   localparam logic REQ_SET   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic REG_POSITIONS = 1'b0;
   localparam logic REG_RANKS     = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [POS_W-1:0]  position;
      logic [RANK_W-1:0] value_rank;
      logic [POS_W-1:0]  range_left;
      logic [POS_W-1:0]  range_right;
      logic [K_W-1:0]    order_k;
   } drks_req_type;

   typedef struct packed {
      logic [RANK_W-1:0] answer_rank;
      logic              ok;
   } drks_rsp_type;

endpackage

/* design/drks_ram.sv */
module drks_ram #(
   parameter int WIDTH  = 11,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [0:(1 << ADDR_W)-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* design/dynamic_range_kth_smallest_unit.sv */
// range k-th smallest over a fenwick tree of count trees, all counts in one ram
// set: read the old rank of the position, then a read and a write per count node touched
//   (fenwick nodes from the position up times the rank tree depth, twice when the position was filled)
// query: per rank tree level, one ram read per fenwick node of right and of left-1
// one transaction in flight; a finished result waits in the output register
// reset and every csr write start a clearing pass over both rams
`include "assert_macros.svh"
module dynamic_range_kth_smallest_unit #(
   parameter int MAX_POSITIONS = drks_pkg::DEF_MAX_POSITIONS,
   parameter int MAX_RANKS     = drks_pkg::DEF_MAX_RANKS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  drks_pkg::drks_req_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output drks_pkg::drks_rsp_type      rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [drks_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [drks_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [drks_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import drks_pkg::*;

   localparam int PIDX_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
   localparam int SEG_W  = $clog2(MAX_RANKS) + 1;
   localparam int RW     = SEG_W - 1;
   localparam int CNT_AW = PIDX_W + SEG_W;
   localparam int FEN_W  = ((PIDX_W > CFG_W) ? PIDX_W : CFG_W) + 1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SET_LOOK, ST_UPD_RD, ST_UPD_WR, ST_Q_RD, ST_Q_DECIDE, ST_DONE
   } state_type;

   function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
      logic [CFG_W-1:0] r;
      if (v == '0) r = CFG_W'(1);
      else if (32'(v) > hi) r = CFG_W'(hi);
      else r = v;
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  positions_ff, positions_in;
   logic [CFG_W-1:0]  ranks_ff, ranks_in;
   logic [CNT_AW-1:0] clr_ff, clr_in;
   logic [FEN_W-1:0]  fen_ff, fen_in;
   logic [FEN_W-1:0]  pos_ff, pos_in;
   logic [FEN_W-1:0]  right_ff, right_in;
   logic [FEN_W-1:0]  leftm1_ff, leftm1_in;
   logic [RW-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [RW-1:0]     tgt_ff, tgt_in, new_rank_ff, new_rank_in;
   logic              dec_ff, dec_in;
   logic              phase_ff, phase_in;
   logic              rd_pend_ff, rd_pend_in, rd_sub_ff, rd_sub_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [CNT_AW-1:0] upd_addr_ff, upd_addr_in;
   drks_rsp_type      res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   drks_rsp_type      rsp_data_ff, rsp_data_in;

   logic              cfg_wr;
   logic [CFG_W-1:0]  cfg_val;
   logic              req_acc;
   logic [FEN_W-1:0]  low_bit, fen_up, fen_dn;
   logic [RW-1:0]     mid;
   logic [SEG_W-1:0]  seg_cur, seg_lchild;
   logic [CFG_W-1:0]  vr_wide;
   logic [FEN_W-1:0]  r_pos, r_left, r_right, r_k;
   logic              set_bad, q_bad;
   logic [RW-1:0]     rank_top, nlo, nhi;
   logic              go_left;

   logic              cnt_we;
   logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]  cnt_wdata, cnt_q;
   logic              pos_we;
   logic [PIDX_W-1:0] pos_waddr, pos_raddr;
   logic [RW:0]       pos_wdata, pos_q;

   drks_ram #(.WIDTH(CNT_W), .ADDR_W(CNT_AW)) u_cnt_ram (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr(cnt_raddr), .rdata(cnt_q)
   );

   drks_ram #(.WIDTH(RW + 1), .ADDR_W(PIDX_W)) u_pos_ram (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_q)
   );

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_val    = csr_pwdata[CFG_W-1:0];
   assign csr_prdata = (csr_paddr[2] == REG_RANKS) ? CSR_DW'(ranks_ff) : CSR_DW'(positions_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign low_bit    = fen_ff & (~fen_ff + FEN_W'(1));
   assign fen_up     = fen_ff + low_bit;
   assign fen_dn     = fen_ff - low_bit;
   assign mid        = RW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign seg_cur    = (SEG_W'(lo_ff) + SEG_W'(hi_ff)) | SEG_W'(lo_ff != hi_ff);
   assign seg_lchild = (SEG_W'(lo_ff) + SEG_W'(mid)) | SEG_W'(lo_ff != mid);
   assign rank_top   = RW'(ranks_ff - CFG_W'(1));

   assign r_pos   = FEN_W'(req_data.position);
   assign r_left  = FEN_W'(req_data.range_left);
   assign r_right = FEN_W'(req_data.range_right);
   assign r_k     = FEN_W'(req_data.order_k);
   assign vr_wide = CFG_W'(req_data.value_rank);
   assign set_bad = (r_pos == '0) || (r_pos > FEN_W'(positions_ff));
   assign q_bad   = (r_left == '0) || (r_right > FEN_W'(positions_ff)) || (r_left > r_right)
                    || (r_k == '0) || (r_k > (r_right - r_left + FEN_W'(1)));

   assign go_left = (ACC_W'(k_ff) <= acc_ff);
   assign nlo     = go_left ? lo_ff : RW'(mid + RW'(1));
   assign nhi     = go_left ? mid : hi_ff;

   always_comb begin
      state_in     = state_ff;
      positions_in = positions_ff;
      ranks_in     = ranks_ff;
      clr_in       = clr_ff;
      fen_in       = fen_ff;
      pos_in       = pos_ff;
      right_in     = right_ff;
      leftm1_in    = leftm1_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      tgt_in       = tgt_ff;
      new_rank_in  = new_rank_ff;
      dec_in       = dec_ff;
      phase_in     = phase_ff;
      rd_pend_in   = 1'b0;
      rd_sub_in    = rd_sub_ff;
      k_in         = k_ff;
      upd_addr_in  = upd_addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      acc_in       = acc_ff;
      if (rd_pend_ff) begin
         acc_in = rd_sub_ff ? (acc_ff - ACC_W'(cnt_q)) : (acc_ff + ACC_W'(cnt_q));
      end

      cnt_we    = 1'b0;
      cnt_waddr = upd_addr_ff;
      cnt_wdata = dec_ff ? (cnt_q - CNT_W'(1)) : (cnt_q + CNT_W'(1));
      cnt_raddr = {fen_ff[PIDX_W-1:0], seg_cur};
      pos_we    = 1'b0;
      pos_waddr = pos_ff[PIDX_W-1:0];
      pos_wdata = {1'b1, new_rank_ff};
      pos_raddr = r_pos[PIDX_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            pos_we    = 1'b1;
            pos_waddr = clr_ff[CNT_AW-1 -: PIDX_W];
            pos_wdata = '0;
            clr_in    = clr_ff + CNT_AW'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               pos_in    = r_pos;
               right_in  = r_right;
               leftm1_in = r_left - FEN_W'(1);
               k_in      = req_data.order_k;
               lo_in     = '0;
               hi_in     = rank_top;
               new_rank_in = (vr_wide >= ranks_ff) ? rank_top : RW'(vr_wide);
               res_in.answer_rank = '0;
               res_in.ok          = 1'b0;
               if (req_data.req_type == REQ_SET) begin
                  state_in = set_bad ? ST_DONE : ST_SET_LOOK;
               end else if (q_bad) begin
                  state_in = ST_DONE;
               end else if (rank_top == '0) begin
                  res_in.ok = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  fen_in   = r_right;
                  phase_in = 1'b0;
                  acc_in   = '0;
                  state_in = ST_Q_RD;
               end
            end
         end
         ST_SET_LOOK: begin
            pos_we = 1'b1;
            dec_in = pos_q[RW];
            tgt_in = pos_q[RW] ? pos_q[RW-1:0] : new_rank_ff;
            fen_in = pos_ff;
            lo_in  = '0;
            hi_in  = rank_top;
            state_in = ST_UPD_RD;
         end
         ST_UPD_RD: begin
            upd_addr_in = {fen_ff[PIDX_W-1:0], seg_cur};
            state_in    = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cnt_we   = 1'b1;
            state_in = ST_UPD_RD;
            if (lo_ff != hi_ff) begin
               if (tgt_ff <= mid) begin
                  hi_in = mid;
               end else begin
                  lo_in = RW'(mid + RW'(1));
               end
            end else begin
               lo_in = '0;
               hi_in = rank_top;
               if (fen_up <= FEN_W'(positions_ff)) begin
                  fen_in = fen_up;
               end else if (dec_ff) begin
                  dec_in = 1'b0;
                  tgt_in = new_rank_ff;
                  fen_in = pos_ff;
               end else begin
                  res_in.ok = 1'b1;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_Q_RD: begin
            cnt_raddr = {fen_ff[PIDX_W-1:0], seg_lchild};
            if (fen_ff != '0) begin
               rd_pend_in = 1'b1;
               rd_sub_in  = phase_ff;
               fen_in     = fen_dn;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               fen_in   = leftm1_ff;
            end else begin
               state_in = ST_Q_DECIDE;
            end
         end
         ST_Q_DECIDE: begin
            lo_in = nlo;
            hi_in = nhi;
            if (!go_left) begin
               k_in = k_ff - K_W'(acc_ff);
            end
            if (nlo == nhi) begin
               res_in.answer_rank = RANK_W'(nlo);
               res_in.ok          = 1'b1;
               state_in           = ST_DONE;
            end else begin
               fen_in   = right_ff;
               phase_in = 1'b0;
               acc_in   = '0;
               state_in = ST_Q_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (cfg_wr) begin
         if (csr_paddr[2] == REG_RANKS) begin
            ranks_in = clamp_cfg(cfg_val, MAX_RANKS);
         end else begin
            positions_in = clamp_cfg(cfg_val, MAX_POSITIONS);
         end
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         positions_ff <= clamp_cfg(CFG_W'(CFG_RESET_VALUE), MAX_POSITIONS);
         ranks_ff     <= clamp_cfg(CFG_W'(CFG_RESET_VALUE), MAX_RANKS);
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         positions_ff <= positions_in;
         ranks_ff     <= ranks_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fen_ff      <= fen_in;
      pos_ff      <= pos_in;
      right_ff    <= right_in;
      leftm1_ff   <= leftm1_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tgt_ff      <= tgt_in;
      new_rank_ff <= new_rank_in;
      dec_ff      <= dec_in;
      phase_ff    <= phase_in;
      rd_sub_ff   <= rd_sub_in;
      acc_ff      <= acc_in;
      k_ff        <= k_in;
      upd_addr_ff <= upd_addr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   `DRKS_ASSERT_NORST(a_reset_clears, clock, reset |=> state_ff == ST_CLEAR, "reset must start clear")
   `DRKS_ASSERT(a_upd_order, clock, reset, (state_ff == ST_UPD_WR) |-> ($past(state_ff) == ST_UPD_RD), "count write without read")
   `DRKS_ASSERT(a_done_hold, clock, reset, (state_ff == ST_DONE && rsp_valid_ff && rsp_stall && !cfg_wr) |=> (state_ff == ST_DONE), "result dropped while output busy")
   `DRKS_ASSERT(a_ram_write, clock, reset, cnt_we |-> (state_ff == ST_CLEAR || state_ff == ST_UPD_WR), "count ram written outside clear or update")
endmodule
